@@ hdl/ptrd_pkg.sv @@
// shared types, constants and trit decode table for the packed ternary row dot product
// no dependencies
`default_nettype none

package ptrd_pkg;

  localparam int unsigned CODE_W    = 8;
  localparam int unsigned SCALE_W   = 16;
  localparam int unsigned ACC_W     = 32;
  localparam int unsigned RESULT_W  = 36;
  localparam int unsigned FRAC_W    = 12;
  localparam int unsigned MAX_TRITS = 5;
  localparam int unsigned TABLE_N   = 256;
  localparam int unsigned VALID_N   = 243;

  localparam logic [1:0] TRIT_NEG  = 2'd0;
  localparam logic [1:0] TRIT_SKIP = 2'd1;
  localparam logic [1:0] TRIT_POS  = 2'd2;

  typedef logic [MAX_TRITS-1:0][1:0] trits_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] sum;
    logic [SCALE_W-1:0]      scale;
    logic                    bad;
  } row_t;

  function automatic logic [TABLE_N-1:0][2*MAX_TRITS-1:0] build_trit_table();
    logic [TABLE_N-1:0][2*MAX_TRITS-1:0] tbl;
    trits_t dg;
    logic   carry;
    for (int n = 0; n < TABLE_N; n++) begin
      tbl[n] = {MAX_TRITS{TRIT_SKIP}};
    end
    dg = '0;
    for (int n = 0; n < VALID_N; n++) begin
      tbl[n] = dg;
      carry = 1'b1;
      for (int j = 0; j < MAX_TRITS; j++) begin
        if (carry) begin
          if (dg[j] == TRIT_POS) begin
            dg[j] = TRIT_NEG;
          end else begin
            dg[j] = dg[j] + 2'd1;
            carry = 1'b0;
          end
        end
      end
    end
    return tbl;
  endfunction

  localparam logic [TABLE_N-1:0][2*MAX_TRITS-1:0] TRIT_TABLE = build_trit_table();

endpackage

`default_nettype wire

@@ hdl/packed_ternary_row_dot_product_core.sv @@
// a row total passes the row register, then the output register
// throughput: one item per cycle unless stalled, set by the decode and accumulate stage
// the scale multiply sits in its own stage between the row register and the output register
// reset clears the accumulator, the error flag and all valid bits
// top level, depends on ptrd_pkg, ptrd_accum and ptrd_scale
`default_nettype none

module packed_ternary_row_dot_product_core
  import ptrd_pkg::*;
#(
  parameter int unsigned TRITS_PER_BYTE = 5,
  parameter int unsigned ACT_WIDTH      = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic [CODE_W-1:0]           code_i,
  input  wire logic signed [ACT_WIDTH-1:0] act0_i,
  input  wire logic signed [ACT_WIDTH-1:0] act1_i,
  input  wire logic signed [ACT_WIDTH-1:0] act2_i,
  input  wire logic signed [ACT_WIDTH-1:0] act3_i,
  input  wire logic signed [ACT_WIDTH-1:0] act4_i,
  input  wire logic [SCALE_W-1:0]          row_scale_i,
  input  wire logic                        row_last_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      logic signed [RESULT_W-1:0]  row_result_o,
  output      logic                        bad_code_o
);

  logic [MAX_TRITS-1:0][ACT_WIDTH-1:0] act;
  logic                                row_valid, row_stall;
  row_t                                row;

  assign act[0] = act0_i;
  assign act[1] = act1_i;
  assign act[2] = act2_i;
  assign act[3] = act3_i;
  assign act[4] = act4_i;

  ptrd_accum #(
    .TRITS_PER_BYTE (TRITS_PER_BYTE),
    .ACT_WIDTH      (ACT_WIDTH)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .code_i      (code_i),
    .act_i       (act),
    .row_scale_i (row_scale_i),
    .row_last_i  (row_last_i),
    .row_valid_o (row_valid),
    .row_stall_i (row_stall),
    .row_o       (row)
  );

  ptrd_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .row_valid_i  (row_valid),
    .row_stall_o  (row_stall),
    .row_i        (row),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .row_result_o (row_result_o),
    .bad_code_o   (bad_code_o)
  );

endmodule

`default_nettype wire

@@ hdl/ptrd_accum.sv @@
// input register, trit decode and saturating row accumulator
// depends on ptrd_pkg
`default_nettype none

module ptrd_accum
  import ptrd_pkg::*;
#(
  parameter int unsigned TRITS_PER_BYTE = 5,
  parameter int unsigned ACT_WIDTH      = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output      logic                                in_stall_o,
  input  wire logic [CODE_W-1:0]                   code_i,
  input  wire logic [MAX_TRITS-1:0][ACT_WIDTH-1:0] act_i,
  input  wire logic [SCALE_W-1:0]                  row_scale_i,
  input  wire logic                                row_last_i,
  output      logic                                row_valid_o,
  input  wire logic                                row_stall_i,
  output      row_t                                row_o
);

  localparam int unsigned ITEM_W  = ACT_WIDTH + 3;
  localparam int unsigned WIDE_W  = (ITEM_W > ACC_W) ? ITEM_W : ACC_W;
  localparam int unsigned EXT_W   = WIDE_W + 1;
  localparam int unsigned LIMIT_W = CODE_W + 1;
  localparam logic [LIMIT_W-1:0] CODE_LIMIT = LIMIT_W'(3 ** TRITS_PER_BYTE);
  localparam logic signed [EXT_W-1:0] SUM_MAX =
    EXT_W'({1'b0, {(ACC_W-1){1'b1}}});
  localparam logic signed [EXT_W-1:0] SUM_MIN =
    -EXT_W'({1'b0, {(ACC_W-1){1'b1}}}) - EXT_W'(1);

  logic                                s0_valid_q;
  logic [CODE_W-1:0]                   code_q;
  logic [MAX_TRITS-1:0][ACT_WIDTH-1:0] act_q;
  logic [SCALE_W-1:0]                  scale_q;
  logic                                last_q;

  logic signed [ACC_W-1:0] row_sum_q, row_sum_d;
  logic                    bad_seen_q, bad_seen_d;

  logic                    s0_fire, s0_load;
  logic                    bad_now;
  trits_t                  trits;
  logic signed [ITEM_W-1:0] item_sum;
  logic signed [EXT_W-1:0]  acc_ext;
  logic signed [ACC_W-1:0]  acc_sat;

  assign s0_fire    = s0_valid_q && (!last_q || !row_stall_i);
  assign s0_load    = !s0_valid_q || s0_fire;
  assign in_stall_o = !s0_load;

  assign bad_now = ({1'b0, code_q} >= CODE_LIMIT);
  assign trits   = TRIT_TABLE[code_q];

  always_comb begin
    logic signed [ITEM_W-1:0] a;
    item_sum = '0;
    for (int i = 0; i < TRITS_PER_BYTE; i++) begin
      a = ITEM_W'($signed(act_q[i]));
      case (trits[i])
        TRIT_POS: item_sum = item_sum + a;
        TRIT_NEG: item_sum = item_sum - a;
        default:  item_sum = item_sum;
      endcase
    end
    if (bad_now) begin
      item_sum = '0;
    end
  end

  always_comb begin
    acc_ext = EXT_W'(row_sum_q) + EXT_W'(item_sum);
    if (acc_ext > SUM_MAX) begin
      acc_sat = SUM_MAX[ACC_W-1:0];
    end else if (acc_ext < SUM_MIN) begin
      acc_sat = SUM_MIN[ACC_W-1:0];
    end else begin
      acc_sat = acc_ext[ACC_W-1:0];
    end
  end

  always_comb begin
    row_sum_d  = row_sum_q;
    bad_seen_d = bad_seen_q;
    if (s0_fire) begin
      if (last_q) begin
        row_sum_d  = '0;
        bad_seen_d = 1'b0;
      end else begin
        row_sum_d  = acc_sat;
        bad_seen_d = bad_seen_q | bad_now;
      end
    end
  end

  assign row_valid_o = s0_valid_q && last_q;
  assign row_o.sum   = acc_sat;
  assign row_o.scale = scale_q;
  assign row_o.bad   = bad_seen_q | bad_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      row_sum_q  <= '0;
      bad_seen_q <= 1'b0;
    end else begin
      if (s0_load) begin
        s0_valid_q <= in_valid_i;
      end
      row_sum_q  <= row_sum_d;
      bad_seen_q <= bad_seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_load && in_valid_i) begin
      code_q  <= code_i;
      act_q   <= act_i;
      scale_q <= row_scale_i;
      last_q  <= row_last_i;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ptrd_scale.sv @@
// row total register, scale multiply and output register
// depends on ptrd_pkg
`default_nettype none

module ptrd_scale
  import ptrd_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       row_valid_i,
  output      logic                       row_stall_o,
  input  wire row_t                       row_i,
  output      logic                       out_valid_o,
  input  wire logic                       out_stall_i,
  output      logic signed [RESULT_W-1:0] row_result_o,
  output      logic                       bad_code_o
);

  localparam int unsigned PROD_W = SCALE_W + 1 + ACC_W;

  logic                       s1_valid_q;
  row_t                       row_q;
  logic                       out_valid_q;
  logic signed [RESULT_W-1:0] result_q, result_d;
  logic                       bad_q;
  logic                       out_load, s1_load;
  logic signed [PROD_W-1:0]   prod;

  assign out_load    = !out_valid_q || !out_stall_i;
  assign s1_load     = !s1_valid_q || out_load;
  assign row_stall_o = !s1_load;

  assign prod     = $signed({1'b0, row_q.scale}) * PROD_W'(row_q.sum);
  assign result_d = prod[FRAC_W+RESULT_W-1:FRAC_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= row_valid_i;
      end
      if (out_load) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load && row_valid_i) begin
      row_q <= row_i;
    end
    if (out_load && s1_valid_q) begin
      result_q <= result_d;
      bad_q    <= row_q.bad;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign row_result_o = result_q;
  assign bad_code_o   = bad_q;

endmodule

`default_nettype wire
